// File: hdl/spf_pkg.sv
`timescale 1ns / 1ps

package spf_pkg;

  // Widths fixed by the frame format
  localparam int CountW = 9;
  localparam int MaxMarkerBytesDefault = 4;

  // Largest ID byte that is accepted
  localparam logic [7:0] IdLimit = 8'd14;

  // Register reset values
  localparam logic [31:0] StartPatternReset   = 32'd43605;
  localparam logic [2:0]  StartLengthReset    = 3'd2;
  localparam logic [31:0] EndPatternReset     = 32'd0;
  localparam logic [2:0]  EndLengthReset      = 3'd0;
  localparam logic        LengthFieldOnReset  = 1'b1;
  localparam logic [7:0]  MaxPayloadReset     = 8'd255;
  localparam logic [2:0]  ChecksumLengthReset = 3'd1;
  localparam logic        VariablePayloadReset = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ID    = 3'd1,
    PH_LEN   = 3'd2,
    PH_COUNT = 3'd3,
    PH_END   = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    REJ_NONE     = 2'd0,
    REJ_BAD_ID   = 2'd1,
    REJ_OVERSIZE = 2'd2,
    REJ_NO_END   = 2'd3
  } reject_t;

  typedef enum logic [2:0] {
    CFG_START_PATTERN    = 3'd0,
    CFG_START_LENGTH     = 3'd1,
    CFG_END_PATTERN      = 3'd2,
    CFG_END_LENGTH       = 3'd3,
    CFG_LENGTH_FIELD_ON  = 3'd4,
    CFG_MAX_PAYLOAD      = 3'd5,
    CFG_CHECKSUM_LENGTH  = 3'd6,
    CFG_VARIABLE_PAYLOAD = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] start_pattern;
    logic [2:0]  start_length;
    logic [31:0] end_pattern;
    logic [2:0]  end_length;
    logic        length_field_on;
    logic [7:0]  max_payload;
    logic [2:0]  checksum_length;
    logic        variable_payload;
  } cfg_t;

  typedef struct packed {
    logic              found;
    phase_t            phase;
    logic [CountW-1:0] count;
    reject_t           reject;
  } result_t;

  // Marker byte at a position; positions past the fourth read as zero
  function automatic logic [7:0] marker_byte(input logic [31:0] pat, input int idx);
    logic [31:0] sh;
    sh = '0;
    if (idx >= 0 && idx < 4) begin
      sh = pat >> (8 * idx);
    end
    return sh[7:0];
  endfunction

endpackage

// File: hdl/serial_packet_framer.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   rx_byte
// out       output     out_valid / out_stall packet_found, phase, frame_count, reject_code
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall is low; a byte's result passes the input register,
// then the result register, and the frame step sits between the two.
// Reset (rst, synchronous) empties both registers, clears the frame and loads the
// register defaults; no clearing pass is needed.
// While out_stall holds a result, one more byte is taken into the input register;
// after that in_stall rises. cfg_ready is always high.

module serial_packet_framer #(
  parameter int MaxMarkerBytes = spf_pkg::MaxMarkerBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        packet_found,
  output logic [2:0]  phase,
  output logic [8:0]  frame_count,
  output logic [1:0]  reject_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import spf_pkg::*;

  logic       in_full, out_full, advance;
  logic [7:0] rx_q;
  cfg_t       cfg;
  result_t    res, res_q;

  assign cfg_ready = 1'b1;

  spf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the held word on when the result register is free or being taken
  assign advance  = in_full & (~out_full | ~out_stall);
  assign in_stall = in_full & ~advance;

  spf_step #(
    .MaxMarkerBytes (MaxMarkerBytes)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .rx_byte (rx_q),
    .cfg     (cfg),
    .res     (res)
  );

  // Occupancy of the input and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      out_full <= 1'b0;
    end else begin
      if (!in_stall) in_full <= in_valid;
      if (!out_full || !out_stall) out_full <= in_full;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) rx_q <= rx_byte;
    if (advance) res_q <= res;
  end

  assign out_valid    = out_full;
  assign packet_found = res_q.found;
  assign phase        = res_q.phase;
  assign frame_count  = res_q.count;
  assign reject_code  = res_q.reject;

endmodule

// File: hdl/spf_cfg_regs.sv
`timescale 1ns / 1ps

module spf_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [2:0]    wr_index,
  input  logic [31:0]   wr_data,
  output spf_pkg::cfg_t cfg
);
  import spf_pkg::*;

  // Hold the register file; take a write word when enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_pattern    <= StartPatternReset;
      cfg.start_length     <= StartLengthReset;
      cfg.end_pattern      <= EndPatternReset;
      cfg.end_length       <= EndLengthReset;
      cfg.length_field_on  <= LengthFieldOnReset;
      cfg.max_payload      <= MaxPayloadReset;
      cfg.checksum_length  <= ChecksumLengthReset;
      cfg.variable_payload <= VariablePayloadReset;
    end else if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_START_PATTERN:    cfg.start_pattern    <= wr_data;
        CFG_START_LENGTH:     cfg.start_length     <= wr_data[2:0];
        CFG_END_PATTERN:      cfg.end_pattern      <= wr_data;
        CFG_END_LENGTH:       cfg.end_length       <= wr_data[2:0];
        CFG_LENGTH_FIELD_ON:  cfg.length_field_on  <= wr_data[0];
        CFG_MAX_PAYLOAD:      cfg.max_payload      <= wr_data[7:0];
        CFG_CHECKSUM_LENGTH:  cfg.checksum_length  <= wr_data[2:0];
        CFG_VARIABLE_PAYLOAD: cfg.variable_payload <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/spf_step.sv
`timescale 1ns / 1ps

module spf_step #(
  parameter int MaxMarkerBytes = spf_pkg::MaxMarkerBytesDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  logic [7:0]       rx_byte,
  input  spf_pkg::cfg_t    cfg,
  output spf_pkg::result_t res
);
  import spf_pkg::*;

  localparam int WinW = 8 * MaxMarkerBytes;
  localparam int LenW = $clog2(MaxMarkerBytes + 1);
  localparam int SumW = CountW + 1;

  phase_t            phase, phase_next;
  logic [CountW-1:0] count, count_next;
  logic [WinW-1:0]   swin, swin_next;
  logic [WinW-1:0]   twin, twin_next;
  logic [7:0]        payload_size, payload_size_next;

  logic [LenW-1:0]   s_len, e_len;
  logic [CountW-1:0] k, c1, cnt_hunt;
  logic [WinW-1:0]   hwin, tshift;
  logic              mismatch, hit, done, found;
  logic [SumW-1:0]   cnt_inc, total, end_min, end_max;
  reject_t           rej;

  // Frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      count        <= '0;
      swin         <= '0;
      twin         <= '0;
      payload_size <= MaxPayloadReset;
    end else if (step_en) begin
      phase        <= phase_next;
      count        <= count_next;
      swin         <= swin_next;
      twin         <= twin_next;
      payload_size <= payload_size_next;
    end
  end

  // One byte step: hunt, ID, length, count or end search
  always_comb begin
    // Clamp marker lengths to the window depth; a zero start length acts as one
    if (int'(cfg.start_length) > MaxMarkerBytes) s_len = LenW'(MaxMarkerBytes);
    else s_len = LenW'(cfg.start_length);
    if (s_len == '0) s_len = LenW'(1);
    if (int'(cfg.end_length) > MaxMarkerBytes) e_len = LenW'(MaxMarkerBytes);
    else e_len = LenW'(cfg.end_length);

    cnt_inc = SumW'(count) + SumW'(1);
    total   = SumW'(s_len) + SumW'(cfg.length_field_on) + SumW'(payload_size)
            + SumW'(cfg.checksum_length) + SumW'(e_len);
    end_min = SumW'(s_len) + SumW'(e_len) + SumW'(1);
    end_max = SumW'(s_len) + SumW'(cfg.max_payload) + SumW'(e_len);

    // Hunt window: drop oldest bytes down to one short of the marker, append
    if (count >= CountW'(s_len)) k = count - CountW'(s_len) + CountW'(1);
    else k = '0;
    c1   = count - k;
    hwin = swin >> {k, 3'b000};
    for (int i = 0; i < MaxMarkerBytes; i++) begin
      if (CountW'(i) == c1) hwin[8*i +: 8] = rx_byte;
    end
    cnt_hunt = c1 + CountW'(1);
    mismatch = 1'b0;
    for (int i = 0; i < MaxMarkerBytes; i++) begin
      if (CountW'(i) < cnt_hunt &&
          hwin[8*i +: 8] != marker_byte(cfg.start_pattern, i)) mismatch = 1'b1;
    end

    // Tail window: newest byte at the top, end marker sits in the top bytes
    tshift = twin >> 8;
    tshift[WinW-8 +: 8] = rx_byte;
    hit = 1'b1;
    for (int j = 0; j < MaxMarkerBytes; j++) begin
      if (j >= MaxMarkerBytes - int'(e_len) &&
          tshift[8*j +: 8] !=
            marker_byte(cfg.end_pattern, j + int'(e_len) - MaxMarkerBytes)) hit = 1'b0;
    end

    phase_next        = phase;
    count_next        = count;
    swin_next         = swin;
    twin_next         = twin;
    payload_size_next = payload_size;
    found             = 1'b0;
    rej               = REJ_NONE;
    done              = 1'b0;

    case (phase)
      PH_HUNT: begin
        if (mismatch) begin
          swin_next  = hwin >> 8;
          count_next = cnt_hunt - CountW'(1);
        end else begin
          swin_next  = hwin;
          count_next = cnt_hunt;
          if (cnt_hunt == CountW'(s_len)) phase_next = PH_ID;
        end
      end
      PH_ID: begin
        if (rx_byte > IdLimit) begin
          rej  = REJ_BAD_ID;
          done = 1'b1;
        end else begin
          count_next = CountW'(cnt_inc);
          if (cfg.length_field_on) begin
            phase_next = PH_LEN;
          end else if (cfg.variable_payload) begin
            phase_next = PH_END;
            twin_next  = '0;
          end else begin
            phase_next        = PH_COUNT;
            payload_size_next = cfg.max_payload;
          end
        end
      end
      PH_LEN: begin
        count_next        = CountW'(cnt_inc);
        payload_size_next = rx_byte;
        phase_next        = PH_COUNT;
      end
      PH_COUNT: begin
        count_next = CountW'(cnt_inc);
        if (payload_size > cfg.max_payload) begin
          rej  = REJ_OVERSIZE;
          done = 1'b1;
        end else if (cnt_inc >= total) begin
          found = 1'b1;
          done  = 1'b1;
        end
      end
      PH_END: begin
        count_next = CountW'(cnt_inc);
        twin_next  = tshift;
        if (cnt_inc >= end_min) begin
          if (hit) begin
            found = 1'b1;
            done  = 1'b1;
          end else if (cnt_inc >= end_max) begin
            rej  = REJ_NO_END;
            done = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
        count_next = '0;
        swin_next  = '0;
        twin_next  = '0;
      end
    endcase

    res.found  = found;
    res.reject = rej;
    res.count  = count_next;
    res.phase  = phase_next;

    // Drop the frame on completion or reject; the count is shown before clearing
    if (done) begin
      phase_next = PH_HUNT;
      count_next = '0;
      swin_next  = '0;
      twin_next  = '0;
      res.phase  = PH_HUNT;
    end
  end

`ifndef ASSERT_OFF
  a_hunt_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (count < CountW'(MaxMarkerBytes)))
    else $error("hunt window count reached the window depth");

  a_found_no_reject: assert property (@(posedge clk) disable iff (rst)
    !(res.found && res.reject != REJ_NONE))
    else $error("frame both completed and rejected");

  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    (step_en && (res.found || res.reject != REJ_NONE)) |=>
      (phase == PH_HUNT && count == '0))
    else $error("frame not cleared after completion or reject");
`endif

endmodule

// File: test/serial_packet_framer_tb.sv
`timescale 1ns / 1ps

module serial_packet_framer_tb;
  import spf_pkg::*;

  localparam int MarkerBytes = MaxMarkerBytesDefault;
  localparam int CycleLimit = 200000;
  localparam int WordsPerPhase = 50;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        packet_found;
  logic [2:0]  phase;
  logic [8:0]  frame_count;
  logic [1:0]  reject_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_START_PATTERN;
  logic [31:0] cfg_data = 32'h0;

  serial_packet_framer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .packet_found(packet_found),
    .phase(phase),
    .frame_count(frame_count),
    .reject_code(reject_code),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow registers and frame state of the framer
  cfg_t       shadow_cfg;
  phase_t     frame_phase;
  int         byte_count;
  logic [7:0] start_win [MarkerBytes];
  logic [7:0] tail_win [MarkerBytes];
  int         payload_size;

  // Bytes waiting to be sent, and framer results still owed
  logic [7:0] pending_bytes [$];
  result_t    expected_results [$];
  result_t    want;
  int         bytes_queued = 0;
  int         bytes_taken = 0;
  int         results_seen = 0;
  int         mismatch_count = 0;
  int         cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       rx_accepted = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] marker_octet(input logic [31:0] pat, input int idx);
    if (idx < 4) begin
      return pat[8*idx +: 8];
    end
    return 8'h00;
  endfunction

  function automatic int clamp_marker(input logic [2:0] len);
    return (len > MarkerBytes) ? MarkerBytes : int'(len);
  endfunction

  task automatic shift_start();
    for (int i = 0; i + 1 < MarkerBytes; i++) begin
      start_win[i] = start_win[i + 1];
    end
    start_win[MarkerBytes - 1] = 8'h00;
    if (byte_count > 0) begin
      byte_count--;
    end
  endtask

  task automatic clear_frame();
    frame_phase = PH_HUNT;
    byte_count = 0;
    for (int i = 0; i < MarkerBytes; i++) begin
      start_win[i] = 8'h00;
      tail_win[i] = 8'h00;
    end
  endtask

  // Advance the frame state by one byte and record the result it owes
  task automatic step_framer(input logic [7:0] b);
    int s;
    int e;
    int lf;
    int i;
    bit hit;
    bit done;
    result_t r;
    s = clamp_marker(shadow_cfg.start_length);
    if (s == 0) begin
      s = 1;
    end
    e = clamp_marker(shadow_cfg.end_length);
    lf = int'(shadow_cfg.length_field_on);
    r.found = 1'b0;
    r.reject = REJ_NONE;
    done = 1'b0;
    case (frame_phase)
      PH_HUNT: begin
        while (byte_count >= s) shift_start();
        start_win[byte_count] = b;
        byte_count++;
        // drop only the oldest byte on the first mismatch
        hit = 1'b1;
        for (i = 0; i < byte_count && hit; i++) begin
          if (start_win[i] != marker_octet(shadow_cfg.start_pattern, i)) begin
            hit = 1'b0;
            shift_start();
          end
        end
        if (hit && byte_count == s) begin
          frame_phase = PH_ID;
        end
      end
      PH_ID: begin
        if (b > IdLimit) begin
          r.reject = REJ_BAD_ID;
          done = 1'b1;
        end else begin
          byte_count++;
          if (lf != 0) begin
            frame_phase = PH_LEN;
          end else if (shadow_cfg.variable_payload) begin
            frame_phase = PH_END;
            for (i = 0; i < MarkerBytes; i++) tail_win[i] = 8'h00;
          end else begin
            frame_phase = PH_COUNT;
            payload_size = int'(shadow_cfg.max_payload);
          end
        end
      end
      PH_LEN: begin
        byte_count++;
        payload_size = int'(b);
        frame_phase = PH_COUNT;
      end
      PH_COUNT: begin
        byte_count++;
        if (payload_size > shadow_cfg.max_payload) begin
          r.reject = REJ_OVERSIZE;
          done = 1'b1;
        end else if (byte_count >= s + lf + payload_size + shadow_cfg.checksum_length + e) begin
          r.found = 1'b1;
          done = 1'b1;
        end
      end
      PH_END: begin
        byte_count++;
        for (i = 0; i + 1 < MarkerBytes; i++) tail_win[i] = tail_win[i + 1];
        tail_win[MarkerBytes - 1] = b;
        if (byte_count >= s + e + 1) begin
          hit = 1'b1;
          for (i = 0; i < e; i++) begin
            if (tail_win[MarkerBytes - e + i] != marker_octet(shadow_cfg.end_pattern, i)) begin
              hit = 1'b0;
            end
          end
          if (hit) begin
            r.found = 1'b1;
            done = 1'b1;
          end else if (byte_count >= s + shadow_cfg.max_payload + e) begin
            r.reject = REJ_NO_END;
            done = 1'b1;
          end
        end
      end
      default: begin
        clear_frame();
      end
    endcase
    byte_count = byte_count % 512;
    r.count = byte_count[8:0];
    if (done) begin
      clear_frame();
    end
    r.phase = frame_phase;
    expected_results = {expected_results, r};
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatch_count++;
    $display("%0t: result %0d: %s is %0d, expected %0d", $realtime, results_seen, what,
             got, exp_val);
  endtask

  // Apply a register write to the shadow copy
  task automatic apply_setting(input cfg_idx_t idx, input logic [31:0] data);
    case (idx)
      CFG_START_PATTERN:    shadow_cfg.start_pattern = data;
      CFG_START_LENGTH:     shadow_cfg.start_length = data[2:0];
      CFG_END_PATTERN:      shadow_cfg.end_pattern = data;
      CFG_END_LENGTH:       shadow_cfg.end_length = data[2:0];
      CFG_LENGTH_FIELD_ON:  shadow_cfg.length_field_on = data[0];
      CFG_MAX_PAYLOAD:      shadow_cfg.max_payload = data[7:0];
      CFG_CHECKSUM_LENGTH:  shadow_cfg.checksum_length = data[2:0];
      CFG_VARIABLE_PAYLOAD: shadow_cfg.variable_payload = data[0];
      default: ;
    endcase
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_setting(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
    bytes_queued++;
  endtask

  // Hold until every byte is taken and every result has come back
  task automatic wait_idle();
    while (bytes_taken != bytes_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Queue one frame for the current setting: mostly well formed, some noise or cut short
  task automatic queue_frame();
    int s;
    int e;
    int roll;
    int len;
    int body;
    int cap;
    int i;
    s = clamp_marker(shadow_cfg.start_length);
    if (s == 0) begin
      s = 1;
    end
    e = clamp_marker(shadow_cfg.end_length);
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
    end else begin
      for (i = 0; i < s; i++) queue_byte(marker_octet(shadow_cfg.start_pattern, i));
      if (roll < 18) begin
        repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          queue_byte(8'($urandom_range(15, 255)));
        end else begin
          queue_byte(8'($urandom_range(0, 14)));
        end
        if (shadow_cfg.length_field_on) begin
          cap = (shadow_cfg.max_payload < 6) ? int'(shadow_cfg.max_payload) : 6;
          len = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cap);
          queue_byte(8'(len));
          body = len + int'(shadow_cfg.checksum_length) + e - 1;
        end else if (shadow_cfg.variable_payload) begin
          body = $urandom_range(0, 6);
        end else begin
          body = int'(shadow_cfg.max_payload) + int'(shadow_cfg.checksum_length) + e - 1;
        end
        if (body < 1 && !(shadow_cfg.variable_payload && !shadow_cfg.length_field_on)) begin
          body = 1;
        end
        repeat (body) queue_byte(8'($urandom_range(0, 255)));
        // close a searched frame with its end marker
        if (shadow_cfg.variable_payload && !shadow_cfg.length_field_on) begin
          for (i = 0; i < e; i++) queue_byte(marker_octet(shadow_cfg.end_pattern, i));
          if (e == 0) begin
            queue_byte(8'($urandom_range(0, 255)));
          end
        end
      end
    end
  endtask

  // Check returned words and predict for every byte taken
  always @(posedge clk) begin : monitor
    if (rst) begin
      rx_accepted <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word, packet_found", packet_found, 0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (packet_found !== want.found) report_mismatch("packet_found", packet_found, want.found);
          if (phase !== want.phase) report_mismatch("phase", phase, want.phase);
          if (frame_count !== want.count) report_mismatch("frame_count", frame_count, want.count);
          if (reject_code !== want.reject) report_mismatch("reject_code", reject_code, want.reject);
        end
        results_seen++;
      end
      if (in_valid && !in_stall) begin
        step_framer(rx_byte);
        bytes_taken++;
      end
      rx_accepted <= in_valid && !in_stall;
    end
  end

  // Present pending bytes and stall the result channel at random
  always @(negedge clk) begin : drive_bytes
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (rx_accepted) begin
        pending_bytes.delete(0);
      end
      if (in_valid && !rx_accepted) begin
        // hold the stalled word
      end else if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        rx_byte <= pending_bytes[0];
      end else begin
        in_valid <= 1'b0;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Bound the run
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CycleLimit) begin
      $display("serial_packet_framer_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] opening_bytes [$];
    logic [7:0] oversize_bytes [$];
    cfg_t setting;
    int first;
    opening_bytes = '{8'h55, 8'h55, 8'hAA, 8'hFF,
                      8'h55, 8'hAA, 8'h0E, 8'h00, 8'h33,
                      8'h55, 8'hAA, 8'h0F,
                      8'h55, 8'hAA, 8'h00, 8'h02, 8'h7F, 8'h80};
    oversize_bytes = '{8'h55, 8'hAA, 8'h01, 8'hFF, 8'h00, 8'h55};
    shadow_cfg = '{StartPatternReset, StartLengthReset, EndPatternReset, EndLengthReset,
                   LengthFieldOnReset, MaxPayloadReset, ChecksumLengthReset,
                   VariablePayloadReset};
    clear_frame();
    payload_size = MaxPayloadReset;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Default setting: a start-marker mismatch, a bad ID, an ID of 14, then 15, two frames
    @(posedge clk);
    send_idle_pct = 33;
    recv_idle_pct = 49;
    foreach (opening_bytes[i]) queue_byte(opening_bytes[i]);
    wait_idle();

    // Length above the maximum, then leave half a start marker in the window
    write_reg(CFG_MAX_PAYLOAD, 32'd3);
    @(posedge clk);
    foreach (oversize_bytes[i]) queue_byte(oversize_bytes[i]);

    for (int n = 0; n < 8; n++) begin
      wait_idle();
      setting.start_pattern = $urandom;
      setting.start_length = 3'($urandom_range(0, 7));
      setting.end_pattern = $urandom;
      setting.end_length = 3'($urandom_range(0, 7));
      setting.length_field_on = 1'($urandom_range(0, 1));
      setting.max_payload = 8'($urandom_range(0, 20));
      setting.checksum_length = 3'($urandom_range(0, 7));
      setting.variable_payload = 1'($urandom_range(0, 1));
      case (n)
        0: begin
          // start marker no longer than the bytes held
          setting.start_length = 3'd1;
          setting.end_length = 3'd0;
          setting.length_field_on = 1'b1;
          setting.max_payload = 8'd255;
          setting.checksum_length = 3'd0;
          setting.variable_payload = 1'b0;
        end
        1: begin
          setting.start_pattern = 32'hFFFF_FFFF;
          setting.start_length = 3'd4;
          setting.end_length = 3'd4;
          setting.length_field_on = 1'b0;
          setting.max_payload = 8'd0;
          setting.checksum_length = 3'd4;
          setting.variable_payload = 1'b0;
        end
        2: begin
          setting.start_length = 3'd3;
          setting.end_length = 3'd2;
          setting.length_field_on = 1'b0;
          setting.max_payload = 8'd12;
          setting.variable_payload = 1'b1;
        end
        3: begin
          // zero start length and over-long end marker
          setting.start_length = 3'd0;
          setting.end_length = 3'd7;
          setting.length_field_on = 1'b1;
          setting.max_payload = 8'd5;
          setting.checksum_length = 3'd7;
          setting.variable_payload = 1'b0;
        end
        4: begin
          setting.start_length = 3'd7;
          setting.end_length = 3'd0;
          setting.length_field_on = 1'b0;
          setting.max_payload = 8'd255;
          setting.checksum_length = 3'd0;
          setting.variable_payload = 1'b1;
        end
        5: begin
          setting.start_length = 3'd2;
          setting.end_pattern = 32'h0;
          setting.end_length = 3'd4;
          setting.length_field_on = 1'b0;
          setting.max_payload = 8'd3;
          setting.checksum_length = 3'd1;
          setting.variable_payload = 1'b1;
        end
        default: ;
      endcase
      write_reg(CFG_START_PATTERN, setting.start_pattern);
      write_reg(CFG_START_LENGTH, setting.start_length);
      write_reg(CFG_END_PATTERN, setting.end_pattern);
      write_reg(CFG_END_LENGTH, setting.end_length);
      write_reg(CFG_LENGTH_FIELD_ON, setting.length_field_on);
      write_reg(CFG_MAX_PAYLOAD, setting.max_payload);
      write_reg(CFG_CHECKSUM_LENGTH, setting.checksum_length);
      write_reg(CFG_VARIABLE_PAYLOAD, setting.variable_payload);

      // Swap the idling sides after three settings, then run the last two without gaps
      @(posedge clk);
      if (n < 3) begin
        send_idle_pct = 33;
        recv_idle_pct = 49;
      end else if (n < 6) begin
        send_idle_pct = 49;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      first = bytes_queued;
      while (bytes_queued - first < WordsPerPhase) queue_frame();
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("serial_packet_framer_tb: PASS");
    end else begin
      $display("serial_packet_framer_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/spf_pkg.sv
hdl/spf_cfg_regs.sv
hdl/spf_step.sv
hdl/serial_packet_framer.sv
test/serial_packet_framer_tb.sv
